// File: design/scl_pkg.sv
package scl_pkg;

  // Fixed widths of the stream fields.
  localparam int FIELD_W         = 12;
  localparam int DAC_W           = 12;
  localparam int REQ_W           = 2;
  localparam int PHASE_W         = 2;
  localparam int HINT_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int IN_DATA_W       = 24;
  localparam int OUT_DATA_W      = 32;
  localparam int SAMPLE_BITS_DEF = 12;

  // DAC code limits and reset values of the target window.
  localparam logic [DAC_W-1:0]   DAC_MAX    = 12'd4095;
  localparam logic [DAC_W-1:0]   DAC_ZERO   = 12'd0;
  localparam logic [DAC_W-1:0]   DAC_START  = 12'd1861;
  localparam logic [FIELD_W-1:0] TLOW_RST   = 12'd3276;
  localparam logic [FIELD_W-1:0] THIGH_RST  = 12'd3549;

  // Percent tests scaled by 1/5: 95%, 100% and 105% become 19, 20 and 21.
  localparam int K_LO  = 19;
  localparam int K_MID = 20;
  localparam int K_HI  = 21;

  // Configuration register indexes.
  localparam logic CFG_TLOW  = 1'b0;
  localparam logic CFG_THIGH = 1'b1;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ABORT  = 2'd2;

  // Calibration phases.
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BAL  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_PEAK = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DAC  = 2'd3;

  // Operator hints.
  localparam logic [HINT_W-1:0] HINT_NONE   = 3'd0;
  localparam logic [HINT_W-1:0] HINT_CW     = 3'd1;
  localparam logic [HINT_W-1:0] HINT_CCW    = 3'd2;
  localparam logic [HINT_W-1:0] HINT_LOWER  = 3'd3;
  localparam logic [HINT_W-1:0] HINT_HIGHER = 3'd4;
  localparam logic [HINT_W-1:0] HINT_MAX    = 3'd5;

  // Sequence status.
  localparam logic [STATUS_W-1:0] ST_RUN     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAIL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABORTED = 2'd3;

  typedef struct packed {
    logic clr;
    logic upd;
  } lane_ctl_t;

  typedef struct packed {
    logic fall;
    logic near;
  } lane_stat_t;

  typedef struct packed {
    logic zero_b;
    logic in_range;
    logic above;
  } ratio_t;

endpackage

// File: design/sensor_calibration_sequencer_core.sv
// A result transaction is registered and presented in the cycle after its input transaction is accepted.
// Throughput: one item per cycle; in_tready drops only while the output register
// holds a result that out_tready has not taken.
// Reset: synchronous on rst_n low; the phase returns to idle, peaks and the fall-off
// flag clear, the DAC code returns to 1861 and the target window to 3276..3549.
module sensor_calibration_sequencer_core #(
  parameter int SAMPLE_BITS = scl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [scl_pkg::IN_DATA_W-1:0]    in_tdata,  // sample_a[11:0], sample_b[23:12]
  input  logic [scl_pkg::REQ_W-1:0]        in_tuser,  // req_type[1:0]
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // phase_now[1:0], hint[4:2], status[6:5], drive_code[18:7],
  // drive_enable[19], calibrated_value[31:20]
  output logic [scl_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [scl_pkg::FIELD_W-1:0]      cfg_wdata
);

  // Samples are masked to SAMPLE_BITS; above the field width nothing is masked.
  localparam int SW = (SAMPLE_BITS < scl_pkg::FIELD_W) ? SAMPLE_BITS : scl_pkg::FIELD_W;

  logic                            in_accept;
  logic [SW-1:0]                   smp_a;
  logic [SW-1:0]                   smp_b;
  logic [scl_pkg::FIELD_W-1:0]     a_ext;
  logic [scl_pkg::REQ_W-1:0]       req;

  logic [scl_pkg::PHASE_W-1:0]     phase_r, phase_nxt;
  logic                            past_peak_r, past_peak_nxt;
  logic [scl_pkg::DAC_W-1:0]       dac_r, dac_nxt;
  logic [scl_pkg::FIELD_W-1:0]     tlow_r;
  logic [scl_pkg::FIELD_W-1:0]     thigh_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [scl_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  logic [scl_pkg::HINT_W-1:0]      hint;
  logic [scl_pkg::STATUS_W-1:0]    status;
  logic [scl_pkg::DAC_W-1:0]       calib;
  logic [scl_pkg::DAC_W-1:0]       drive_code;
  logic                            drive_en;
  logic                            abort_hit;

  scl_pkg::lane_ctl_t              lane_ctl;
  scl_pkg::lane_stat_t             stat_a, stat_b;
  scl_pkg::ratio_t                 ratio;

  // The output register parts the two sides: a new transaction is taken whenever
  // the register is empty or its result leaves in the same cycle.
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign req   = in_tuser;
  assign smp_a = in_tdata[SW-1:0];
  assign smp_b = in_tdata[scl_pkg::FIELD_W +: SW];
  assign a_ext = scl_pkg::FIELD_W'(smp_a);

  // One lane per channel tracks its own peak and judges fall-off and nearness;
  // the sequencer below merges the two verdicts.
  scl_lane #(.SW(SW)) u_lane_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .sample (smp_a),
    .ctl    (lane_ctl),
    .stat   (stat_a)
  );

  scl_lane #(.SW(SW)) u_lane_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .sample (smp_b),
    .ctl    (lane_ctl),
    .stat   (stat_b)
  );

  scl_ratio #(.SW(SW)) u_ratio (
    .sample_a (smp_a),
    .sample_b (smp_b),
    .res      (ratio)
  );

  always_comb begin
    phase_nxt     = phase_r;
    past_peak_nxt = past_peak_r;
    dac_nxt       = dac_r;
    hint          = scl_pkg::HINT_NONE;
    status        = scl_pkg::ST_RUN;
    calib         = '0;
    abort_hit     = 1'b0;
    lane_ctl.clr  = 1'b0;
    lane_ctl.upd  = 1'b0;

    unique case (req)
      scl_pkg::REQ_START: begin
        // A start always restarts at balance with the peaks cleared.
        lane_ctl.clr  = in_accept;
        past_peak_nxt = 1'b0;
        phase_nxt     = scl_pkg::PH_BAL;
      end
      scl_pkg::REQ_ABORT: begin
        if (phase_r != scl_pkg::PH_IDLE) begin
          phase_nxt = scl_pkg::PH_IDLE;
          status    = scl_pkg::ST_ABORTED;
          abort_hit = 1'b1;
        end
      end
      scl_pkg::REQ_SAMPLE: begin
        unique case (phase_r)
          scl_pkg::PH_BAL: begin
            // A zero second sample cannot be balanced and is ignored.
            if (!ratio.zero_b) begin
              if (ratio.in_range) begin
                phase_nxt = scl_pkg::PH_PEAK;
              end else if (ratio.above) begin
                hint = scl_pkg::HINT_CW;
              end else begin
                hint = scl_pkg::HINT_CCW;
              end
            end
          end
          scl_pkg::PH_PEAK: begin
            lane_ctl.upd = in_accept;
            if (!past_peak_r) begin
              hint = scl_pkg::HINT_LOWER;
              if (stat_a.fall || stat_b.fall) begin
                past_peak_nxt = 1'b1;
              end
            end
            // The fall-off found by this very sample already counts.
            if (past_peak_nxt) begin
              hint = scl_pkg::HINT_HIGHER;
              if (stat_a.near && stat_b.near) begin
                hint      = scl_pkg::HINT_MAX;
                phase_nxt = scl_pkg::PH_DAC;
              end
            end
          end
          scl_pkg::PH_DAC: begin
            // A window whose low end lies above its high end is never met.
            if (a_ext >= tlow_r && a_ext <= thigh_r) begin
              status    = scl_pkg::ST_OK;
              calib     = dac_r;
              phase_nxt = scl_pkg::PH_IDLE;
            end else if (a_ext > thigh_r) begin
              if (dac_r == scl_pkg::DAC_MAX) begin
                status    = scl_pkg::ST_FAIL;
                phase_nxt = scl_pkg::PH_IDLE;
              end else begin
                dac_nxt = dac_r + scl_pkg::DAC_W'(1);
              end
            end else begin
              if (dac_r == scl_pkg::DAC_ZERO) begin
                status    = scl_pkg::ST_FAIL;
                phase_nxt = scl_pkg::PH_IDLE;
              end else begin
                dac_nxt = dac_r - scl_pkg::DAC_W'(1);
              end
            end
          end
          scl_pkg::PH_IDLE: begin
            // Samples while idle are ignored.
          end
        endcase
      end
      default: begin
        // The unused request code leaves all state alone.
      end
    endcase

    // The DAC is driven in every active phase; an abort parks it at full scale.
    drive_en = (phase_nxt != scl_pkg::PH_IDLE);
    if (drive_en) begin
      drive_code = dac_nxt;
    end else if (abort_hit) begin
      drive_code = scl_pkg::DAC_MAX;
    end else begin
      drive_code = '0;
    end

    out_data_nxt = {calib, drive_en, drive_code, status, hint, phase_nxt};
    out_valid_nxt = in_accept ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= scl_pkg::PH_IDLE;
      past_peak_r <= 1'b0;
      dac_r       <= scl_pkg::DAC_START;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        phase_r     <= phase_nxt;
        past_peak_r <= past_peak_nxt;
        dac_r       <= dac_nxt;
      end
    end
  end

  // Configuration must only be written while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlow_r  <= scl_pkg::TLOW_RST;
      thigh_r <= scl_pkg::THIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        scl_pkg::CFG_TLOW:  tlow_r  <= cfg_wdata;
        scl_pkg::CFG_THIGH: thigh_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: design/scl_lane.sv
module scl_lane #(
  parameter int SW = scl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SW-1:0]       sample,
  input  scl_pkg::lane_ctl_t  ctl,
  output scl_pkg::lane_stat_t stat
);

  localparam int W = SW + 5;

  logic [SW-1:0] peak_r;
  logic [SW-1:0] peak_nxt;
  logic [SW-1:0] drop;
  logic [W-1:0]  pk_w;
  logic [W-1:0]  x20;
  logic [W-1:0]  x1_20;
  logic [W-1:0]  drop20;

  // The running maximum includes the current sample before any test.
  assign peak_nxt = (sample > peak_r) ? sample : peak_r;
  assign drop     = peak_nxt - sample;
  assign pk_w     = W'(peak_nxt);
  assign x20      = W'(sample) * W'(scl_pkg::K_MID);
  assign x1_20    = (W'(sample) + W'(1)) * W'(scl_pkg::K_MID);
  assign drop20   = W'(drop) * W'(scl_pkg::K_MID);

  // Floor divisions by 20 are folded into exact cross-multiplied compares.
  assign stat.fall = drop20 > pk_w;
  assign stat.near = (x20 > pk_w * W'(scl_pkg::K_LO)) &&
                     (x1_20 <= pk_w * W'(scl_pkg::K_HI));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (ctl.clr) begin
      peak_r <= '0;
    end else if (ctl.upd) begin
      peak_r <= peak_nxt;
    end
  end

endmodule

// File: design/scl_ratio.sv
module scl_ratio #(
  parameter int SW = scl_pkg::SAMPLE_BITS_DEF
) (
  input  logic [SW-1:0]   sample_a,
  input  logic [SW-1:0]   sample_b,
  output scl_pkg::ratio_t res
);

  localparam int W = SW + 5;

  logic [W-1:0] a20;
  logic [W-1:0] b19;
  logic [W-1:0] b21;

  assign a20 = W'(sample_a) * W'(scl_pkg::K_MID);
  assign b19 = W'(sample_b) * W'(scl_pkg::K_LO);
  assign b21 = W'(sample_b) * W'(scl_pkg::K_HI);

  assign res.zero_b   = (sample_b == '0);
  assign res.in_range = (a20 >= b19) && (a20 <= b21);
  assign res.above    = a20 > b21;

endmodule

// File: design/scl_checker.sv
module scl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [scl_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // A result held back by the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // No input is taken while a stalled result occupies the output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !(out_tvalid && !out_tready))
    else $error("input taken over a stalled result");

  // With the drive off the code is zero, or full scale exactly on an abort.
  a_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[19] |->
      (out_tdata[18:7] == '0 && out_tdata[6:5] != scl_pkg::ST_ABORTED) ||
      (out_tdata[18:7] == scl_pkg::DAC_MAX && out_tdata[6:5] == scl_pkg::ST_ABORTED))
    else $error("inconsistent drive code with drive disabled");

  // Finding the maximum always moves on to DAC tuning with the drive on.
  a_max_to_dac: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:2] == scl_pkg::HINT_MAX |->
      out_tdata[1:0] == scl_pkg::PH_DAC && out_tdata[19])
    else $error("max found without entering DAC tuning");

endmodule

bind sensor_calibration_sequencer_core scl_checker u_scl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: bench/tb_sensor_calibration_sequencer_core.sv
`timescale 1ns / 1ps

module tb_sensor_calibration_sequencer_core;

  // The request code above abort has no meaning to the block and must be ignored.
  localparam logic [scl_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  // One input transaction: the request kind rides on tuser, the two samples on tdata.
  typedef struct packed {
    logic [scl_pkg::REQ_W-1:0]   req;
    logic [scl_pkg::FIELD_W-1:0] b;
    logic [scl_pkg::FIELD_W-1:0] a;
  } cal_request_t;

  // One result transaction, laid out exactly as out_tdata (phase in the low bits).
  typedef struct packed {
    logic [scl_pkg::FIELD_W-1:0]  calib;
    logic                         drv_en;
    logic [scl_pkg::DAC_W-1:0]    drv_code;
    logic [scl_pkg::STATUS_W-1:0] status;
    logic [scl_pkg::HINT_W-1:0]   hint;
    logic [scl_pkg::PHASE_W-1:0]  phase;
  } cal_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [scl_pkg::IN_DATA_W-1:0]  in_tdata;   // sample_a[11:0], sample_b[23:12]
  logic [scl_pkg::REQ_W-1:0]      in_tuser;   // req_type[1:0]
  logic                           out_tvalid;
  logic                           out_tready;
  // phase_now[1:0], hint[4:2], status[6:5], drive_code[18:7],
  // drive_enable[19], calibrated_value[31:20]
  logic [scl_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_we;
  logic                           cfg_addr;
  logic [scl_pkg::FIELD_W-1:0]    cfg_wdata;

  sensor_calibration_sequencer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Requests waiting to be driven, and results predicted but not yet seen.
  cal_request_t pending_requests[$];
  cal_result_t  pending_results[$];
  int unsigned  queued_count = 0;
  int           fail_count = 0;
  int           stall_cycles = 0;

  // Idle percentages of the sender and the receiver; the stimulus changes them per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Shadow of the sequencer state and of its target window.
  logic [scl_pkg::PHASE_W-1:0] phase_m = scl_pkg::PH_IDLE;
  logic [scl_pkg::FIELD_W-1:0] pk_a_m = '0;
  logic [scl_pkg::FIELD_W-1:0] pk_b_m = '0;
  logic                        past_peak_m = 1'b0;
  logic [scl_pkg::DAC_W-1:0]   dac_m = scl_pkg::DAC_START;
  logic [scl_pkg::FIELD_W-1:0] tgt_low;
  logic [scl_pkg::FIELD_W-1:0] tgt_high;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // A sample counts as back at its maximum only strictly inside 95%..105% of it,
  // with both bounds truncated toward zero.
  function automatic bit within_peak_band(input int unsigned v, input int unsigned pk);
    return (v > (pk * 95) / 100) && (v < (pk * 105) / 100);
  endfunction

  // Advances the shadow state by one accepted request and returns the result that
  // the block must produce for it.
  function automatic cal_result_t predict_calibration(input cal_request_t rq);
    cal_result_t r;
    int unsigned ua;
    int unsigned ub;
    int unsigned pa;
    int unsigned pb;
    bit          aborted;
    r = '0;
    aborted = 1'b0;
    ua = 32'(rq.a);
    ub = 32'(rq.b);
    case (rq.req)
      scl_pkg::REQ_START: begin
        // A start always (re)opens the balance phase; the DAC code is kept.
        pk_a_m = '0;
        pk_b_m = '0;
        past_peak_m = 1'b0;
        phase_m = scl_pkg::PH_BAL;
      end
      scl_pkg::REQ_ABORT: begin
        if (phase_m != scl_pkg::PH_IDLE) begin
          phase_m = scl_pkg::PH_IDLE;
          r.status = scl_pkg::ST_ABORTED;
          aborted = 1'b1;
        end
      end
      scl_pkg::REQ_SAMPLE: begin
        case (phase_m)
          scl_pkg::PH_BAL: begin
            // The ratio a/b is tested by cross-multiplication; b of zero is skipped.
            if (ub != 0) begin
              if (ua * 100 >= 95 * ub && ua * 100 <= 105 * ub) phase_m = scl_pkg::PH_PEAK;
              else if (ua * 100 > 105 * ub) r.hint = scl_pkg::HINT_CW;
              else r.hint = scl_pkg::HINT_CCW;
            end
          end
          scl_pkg::PH_PEAK: begin
            if (rq.a > pk_a_m) pk_a_m = rq.a;
            if (rq.b > pk_b_m) pk_b_m = rq.b;
            pa = 32'(pk_a_m);
            pb = 32'(pk_b_m);
            if (!past_peak_m) begin
              r.hint = scl_pkg::HINT_LOWER;
              if (pa - ua > (pa * 5) / 100 || pb - ub > (pb * 5) / 100) past_peak_m = 1'b1;
            end
            if (past_peak_m) begin
              r.hint = scl_pkg::HINT_HIGHER;
              if (within_peak_band(ua, pa) && within_peak_band(ub, pb)) begin
                r.hint = scl_pkg::HINT_MAX;
                phase_m = scl_pkg::PH_DAC;
              end
            end
          end
          scl_pkg::PH_DAC: begin
            if (rq.a >= tgt_low && rq.a <= tgt_high) begin
              r.status = scl_pkg::ST_OK;
              r.calib = dac_m;
              phase_m = scl_pkg::PH_IDLE;
            end else if (rq.a > tgt_high) begin
              if (dac_m == scl_pkg::DAC_MAX) begin
                r.status = scl_pkg::ST_FAIL;
                phase_m = scl_pkg::PH_IDLE;
              end else begin
                dac_m = dac_m + scl_pkg::DAC_W'(1);
              end
            end else begin
              if (dac_m == scl_pkg::DAC_ZERO) begin
                r.status = scl_pkg::ST_FAIL;
                phase_m = scl_pkg::PH_IDLE;
              end else begin
                dac_m = dac_m - scl_pkg::DAC_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.phase = phase_m;
    if (phase_m != scl_pkg::PH_IDLE) begin
      r.drv_code = dac_m;
      r.drv_en = 1'b1;
    end else begin
      // The drive is parked at full scale only on the abort result itself.
      r.drv_code = aborted ? scl_pkg::DAC_MAX : scl_pkg::DAC_ZERO;
    end
    return r;
  endfunction

  // Driver: presents the next pending request whenever the bus is free, with
  // random gaps. A request is predicted at the edge on which it is accepted.
  cal_request_t on_bus;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= scl_pkg::REQ_START;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(predict_calibration(on_bus));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {on_bus.b, on_bus.a};
          in_tuser <= on_bus.req;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted result transaction is checked against the oldest
  // prediction, field by field. Backpressure is applied at random.
  task automatic check_result(input cal_result_t got);
    cal_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result transaction 0x%08h with nothing expected", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.phase !== want.phase)
      report_mismatch($sformatf("phase_now: expected %0d, got %0d", want.phase, got.phase));
    if (got.hint !== want.hint)
      report_mismatch($sformatf("hint: expected %0d, got %0d", want.hint, got.hint));
    if (got.status !== want.status)
      report_mismatch($sformatf("status: expected %0d, got %0d", want.status, got.status));
    if (got.drv_code !== want.drv_code)
      report_mismatch($sformatf("drive_code: expected %0d, got %0d",
                                want.drv_code, got.drv_code));
    if (got.drv_en !== want.drv_en)
      report_mismatch($sformatf("drive_enable: expected %0d, got %0d",
                                want.drv_en, got.drv_en));
    if (got.calib !== want.calib)
      report_mismatch($sformatf("calibrated_value: expected %0d, got %0d",
                                want.calib, got.calib));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(cal_result_t'(out_tdata));
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: a long stretch without any transaction on either side means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [scl_pkg::REQ_W-1:0] req, input int unsigned a,
                            input int unsigned b);
    cal_request_t rq;
    rq.req = req;
    rq.a = a[scl_pkg::FIELD_W-1:0];
    rq.b = b[scl_pkg::FIELD_W-1:0];
    pending_requests.push_back(rq);
    queued_count++;
  endtask

  function automatic int unsigned rand12();
    return $urandom_range(0, 4095);
  endfunction

  // DAC-phase sample: often aimed into the target window, otherwise anywhere.
  function automatic int unsigned dac_sample();
    if (tgt_low <= tgt_high && $urandom_range(0, 3) == 0)
      return $urandom_range(int'(tgt_low), int'(tgt_high));
    return rand12();
  endfunction

  // Writes both ends of the target window. Only called while the block is idle.
  task automatic set_window(input int unsigned lo, input int unsigned hi);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= scl_pkg::CFG_TLOW;
    cfg_wdata <= lo[scl_pkg::FIELD_W-1:0];
    @(posedge clk);
    cfg_addr <= scl_pkg::CFG_THIGH;
    cfg_wdata <= hi[scl_pkg::FIELD_W-1:0];
    tgt_low = lo[scl_pkg::FIELD_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    tgt_high = hi[scl_pkg::FIELD_W-1:0];
  endtask

  // Waits until every request was taken and every result came back, with some
  // margin.
  task automatic drain();
    while (pending_requests.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One well-formed calibration attempt with random content. It may be cut short
  // by an abort or a restart, which exercises the broken-sequence paths.
  task automatic queue_attempt();
    int unsigned n;
    int unsigned bb;
    int unsigned v;
    int unsigned pa;
    int unsigned pb;
    queue_item(scl_pkg::REQ_START, rand12(), rand12());
    // Balance: a few off-ratio or zero-b samples, then a roughly matched pair.
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) queue_item(scl_pkg::REQ_SAMPLE, rand12(), 0);
      else queue_item(scl_pkg::REQ_SAMPLE, rand12(), rand12());
    end
    bb = $urandom_range(20, 4095);
    v = bb * $urandom_range(94, 106) / 100;
    if (v > 4095) v = 4095;
    queue_item(scl_pkg::REQ_SAMPLE, v, bb);
    if ($urandom_range(0, 99) < 8) begin
      queue_item($urandom_range(0, 1) ? scl_pkg::REQ_ABORT : scl_pkg::REQ_START,
                 rand12(), rand12());
      return;
    end
    // Peak search: climb to the maxima, fall away from them, come back near them.
    pa = $urandom_range(100, 4095);
    pb = $urandom_range(100, 4095);
    n = $urandom_range(1, 4);
    for (int k = 1; k <= n; k++) queue_item(scl_pkg::REQ_SAMPLE, pa * k / n, pb * k / n);
    n = $urandom_range(0, 2);
    repeat (n)
      queue_item(scl_pkg::REQ_SAMPLE, pa * $urandom_range(60, 98) / 100,
                 pb * $urandom_range(60, 100) / 100);
    queue_item(scl_pkg::REQ_SAMPLE, pa * $urandom_range(96, 100) / 100,
               pb * $urandom_range(96, 100) / 100);
    if ($urandom_range(0, 99) < 8) begin
      queue_item(scl_pkg::REQ_ABORT, rand12(), rand12());
      return;
    end
    // DAC tuning: step the code a while, sometimes hitting the window.
    n = $urandom_range(1, 12);
    repeat (n) queue_item(scl_pkg::REQ_SAMPLE, dac_sample(), rand12());
  endtask

  // Noise: requests of any kind, including the unused code, at any point.
  task automatic queue_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) queue_item(scl_pkg::REQ_W'($urandom_range(0, 3)), rand12(), rand12());
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned goal;
    goal = queued_count + count;
    while (queued_count < goal) begin
      if ($urandom_range(0, 99) < 85) queue_attempt();
      else queue_noise();
    end
  endtask

  initial begin
    int unsigned lo;
    int unsigned hi;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = scl_pkg::CFG_TLOW;
    cfg_wdata = '0;
    tgt_low = scl_pkg::TLOW_RST;
    tgt_high = scl_pkg::THIGH_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The sender rarely idles, the receiver mostly stalls.
    send_idle_pct = 9;
    recv_idle_pct = 62;

    // Directed part, run with the reset window.
    queue_item(scl_pkg::REQ_ABORT, 4095, 4095);    // abort while idle is ignored
    queue_item(scl_pkg::REQ_SAMPLE, 4095, 0);      // sample while idle is ignored
    queue_item(REQ_UNUSED, 0, 4095);               // unused request code
    queue_item(scl_pkg::REQ_START, 4095, 4095);
    queue_item(scl_pkg::REQ_SAMPLE, 1234, 0);      // zero second sample is skipped
    queue_item(scl_pkg::REQ_SAMPLE, 4095, 1);      // far too high a ratio: tilt clockwise
    queue_item(scl_pkg::REQ_SAMPLE, 0, 4095);      // far too low a ratio: tilt anticlockwise
    queue_item(scl_pkg::REQ_SAMPLE, 94, 100);      // just under the lower ratio bound
    queue_item(REQ_UNUSED, 4095, 4095);
    queue_item(scl_pkg::REQ_SAMPLE, 95, 100);      // exactly on the lower ratio bound
    queue_item(scl_pkg::REQ_SAMPLE, 1000, 1000);   // climbing
    queue_item(scl_pkg::REQ_SAMPLE, 4095, 4095);   // maxima at full scale
    queue_item(scl_pkg::REQ_SAMPLE, 3800, 4095);   // fall-off seen, not yet back near the top
    queue_item(scl_pkg::REQ_SAMPLE, 4095, 4000);   // back near both maxima
    queue_item(scl_pkg::REQ_SAMPLE, 4095, 0);      // above the window: code steps up
    queue_item(scl_pkg::REQ_SAMPLE, 0, 0);         // below the window: code steps down
    queue_item(scl_pkg::REQ_SAMPLE, 3276, 77);     // on the low edge of the window: success
    queue_item(scl_pkg::REQ_START, 0, 0);
    queue_item(scl_pkg::REQ_SAMPLE, 106, 100);     // just over the upper ratio bound
    queue_item(scl_pkg::REQ_ABORT, 0, 0);          // abort during balance
    queue_item(scl_pkg::REQ_START, 0, 0);
    queue_item(scl_pkg::REQ_SAMPLE, 105, 100);     // exactly on the upper ratio bound
    queue_item(scl_pkg::REQ_SAMPLE, 3000, 3000);
    queue_item(scl_pkg::REQ_START, 0, 0);          // restart in the middle of peak search
    queue_item(scl_pkg::REQ_ABORT, 0, 0);
    drain();

    // Widest window: any sample lands in it.
    set_window(0, 4095);
    random_phase(200);
    drain();

    lo = $urandom_range(1000, 2500);
    hi = lo + $urandom_range(0, 1500);
    set_window(lo, hi);
    random_phase(200);
    drain();

    // Now the sender mostly idles and the receiver rarely stalls.
    send_idle_pct = 62;
    recv_idle_pct = 9;
    lo = rand12();
    set_window(lo, lo);
    random_phase(200);
    drain();

    // Inverted window: never met, so no DAC phase ends in success.
    set_window(4095, 0);
    random_phase(200);
    drain();

    // No idling on either side from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_window(rand12(), rand12());
    random_phase(200);
    drain();

    set_window(32'(scl_pkg::TLOW_RST), 32'(scl_pkg::THIGH_RST));
    random_phase(200);
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
